// ===== rtl/plts_pkg.sv =====
// Package for the partitioned LRU tag store: action codes, controller state and command types.
package plts_pkg;

  localparam int ActionW = 3;
  localparam int SetIdxW = 8;
  localparam int TagInW  = 18;
  localparam int WayInW  = 2;

  localparam logic [ActionW-1:0] ACT_ACCESS     = 3'd0;
  localparam logic [ActionW-1:0] ACT_PROBE      = 3'd1;
  localparam logic [ActionW-1:0] ACT_VICTIM     = 3'd2;
  localparam logic [ActionW-1:0] ACT_INSERT     = 3'd3;
  localparam logic [ActionW-1:0] ACT_INVALIDATE = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic init_wr;
    logic req_load;
    logic quot_load;
    logic ram_rd;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/plts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/plts_ctrl.sv =====
// Controller state machine for the partitioned LRU tag store.
module plts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plts_pkg::ctrl_sts_t sts_i,
  output plts_pkg::ctrl_cmd_t cmd_o
);
  import plts_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.quot_load = 1'b1;
        state_d         = ST_READ;
      end
      ST_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/plts_dp.sv =====
// Datapath: request registers, set index reduction, set row RAM, update logic, result register.
module plts_dp #(
  parameter int NUM_SETS      = 256,
  parameter int WAYS_PER_PART = 4,
  parameter int TAG_BITS      = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  plts_pkg::ctrl_cmd_t                 cmd_i,
  output plts_pkg::ctrl_sts_t                 sts_o,
  input  logic [plts_pkg::ActionW-1:0]        action_i,
  input  logic                                partition_i,
  input  logic [plts_pkg::SetIdxW-1:0]        set_index_i,
  input  logic [plts_pkg::TagInW-1:0]         tag_i,
  input  logic [plts_pkg::WayInW-1:0]         way_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [plts_pkg::WayInW-1:0]         way_out_o,
  output logic                                victim_valid_o,
  output logic [plts_pkg::TagInW-1:0]         victim_tag_o
);
  import plts_pkg::*;

  localparam int W       = WAYS_PER_PART;
  localparam int TB      = TAG_BITS;
  localparam int WB      = (W > 1) ? $clog2(W) : 1;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ADDR_W  = SET_W + 1;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int TAGS_W  = W * TB;
  localparam int ROW_W   = TAGS_W + 2 * W + W * WB;
  localparam int MAXW    = (TB > TagInW) ? TB : TagInW;
  localparam int RECIP   = 65536 / NUM_SETS;
  localparam int PROD_W  = SetIdxW + 17;

  // Request registers
  logic [ActionW-1:0] act_q;
  logic               part_q;
  logic [SetIdxW-1:0] set_q;
  logic [TB-1:0]      tag_q;
  logic [WayInW-1:0]  way_q;
  logic [SetIdxW-1:0] quot_q;
  logic [ADDR_W-1:0]  init_cnt_q;

  logic [MAXW-1:0]    tag_ext;
  logic [PROD_W-1:0]  quot_prod;
  logic [PROD_W-1:0]  rem_full;
  logic [SET_W-1:0]   set_idx;
  logic [ADDR_W-1:0]  row_addr;

  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   new_row;
  logic [ROW_W-1:0]   reset_row;

  logic               out_valid_q;
  logic               hit_q, vv_q;
  logic [WayInW-1:0]  wo_q;
  logic [TagInW-1:0]  vt_q;
  logic               hit_d, vv_d;
  logic [WayInW-1:0]  wo_d;
  logic [TagInW-1:0]  vt_d;

  assign tag_ext = MAXW'(tag_i);

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q  <= action_i;
      part_q <= partition_i;
      set_q  <= set_index_i;
      tag_q  <= tag_ext[TB-1:0];
      way_q  <= way_i;
    end
  end

  // Estimate the quotient by a reciprocal multiply
  assign quot_prod = PROD_W'(set_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot_load) begin
      quot_q <= quot_prod[16 +: SetIdxW];
    end
  end

  // Remainder with one correction step
  always_comb begin
    rem_full = PROD_W'(set_q) - PROD_W'(quot_q) * PROD_W'(NUM_SETS);
    if (rem_full >= PROD_W'(NUM_SETS)) begin
      rem_full = rem_full - PROD_W'(NUM_SETS);
    end
    set_idx  = rem_full[SET_W-1:0];
    row_addr = {part_q, set_idx};
  end

  // Clearing pass address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init_wr) begin
      init_cnt_q <= init_cnt_q + ADDR_W'(1);
    end
  end

  assign sts_o.init_last = (init_cnt_q == ADDR_W'(DEPTH - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Row after reset: tags hold their way number, order is index order
  always_comb begin
    reset_row = '0;
    for (int k = 0; k < W; k++) begin
      reset_row[k*TB +: TB]                = TB'(k);
      reset_row[TAGS_W + 2*W + k*WB +: WB] = WB'(k);
    end
  end

  plts_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.init_wr | cmd_i.exec),
    .waddr_i(cmd_i.init_wr ? init_cnt_q : row_addr),
    .wdata_i(cmd_i.init_wr ? reset_row : new_row),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(row_addr),
    .rdata_o(rd_row)
  );

  // Lookup and row update
  always_comb begin
    logic [TB-1:0]     tg    [W];
    logic [WB-1:0]     ord   [W];
    logic [WB-1:0]     ord_m [W];
    logic [WB-1:0]     ord_l [W];
    logic [W-1:0]      vld, tch, hit_vec;
    logic              found, pfound;
    logic [WB-1:0]     hw, tgt, pos, lw;
    logic [4:0]        way_ext, wo_ext;
    logic              way_ok;
    logic [WB-1:0]     wsel;
    logic [MAXW-1:0]   vt_ext;

    for (int k = 0; k < W; k++) begin
      tg[k]  = rd_row[k*TB +: TB];
      vld[k] = rd_row[TAGS_W + k];
      tch[k] = rd_row[TAGS_W + W + k];
      ord[k] = rd_row[TAGS_W + 2*W + k*WB +: WB];
      hit_vec[k] = vld[k] && (tg[k] == tag_q);
    end

    // Match nearest MRU wins
    found = 1'b0;
    hw    = '0;
    for (int p = 0; p < W; p++) begin
      if (!found && hit_vec[ord[p]]) begin
        found = 1'b1;
        hw    = ord[p];
      end
    end

    way_ext = 5'(way_q);
    way_ok  = (way_ext < 5'(W));
    wsel    = way_ext[WB-1:0];
    tgt     = (act_q == ACT_ACCESS) ? hw : wsel;

    // Position of the target way in the order
    pfound = 1'b0;
    pos    = '0;
    for (int p = 0; p < W; p++) begin
      if (!pfound && (ord[p] == tgt)) begin
        pfound = 1'b1;
        pos    = WB'(p);
      end
    end

    // Orders with the target moved to MRU and to LRU
    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        ord_m[i] = tgt;
      end else begin
        ord_m[i] = (WB'(i) <= pos) ? ord[i-1] : ord[i];
      end
      if (i == W - 1) begin
        ord_l[i] = tgt;
      end else begin
        ord_l[i] = (WB'(i) < pos) ? ord[i] : ord[(i + 1) % W];
      end
    end

    lw     = ord[W-1];
    hit_d  = 1'b0;
    wo_ext = '0;
    vv_d   = 1'b0;
    vt_ext = '0;

    unique case (act_q)
      ACT_ACCESS: begin
        if (found) begin
          hit_d   = 1'b1;
          wo_ext  = 5'(hw);
          tch[hw] = 1'b1;
          ord     = ord_m;
        end
      end
      ACT_PROBE: begin
        if (found) begin
          hit_d  = 1'b1;
          wo_ext = 5'(hw);
        end
      end
      ACT_VICTIM: begin
        wo_ext = 5'(lw);
        vv_d   = vld[lw];
        vt_ext = MAXW'(tg[lw]);
      end
      ACT_INSERT: begin
        if (way_ok) begin
          tg[wsel]  = tag_q;
          vld[wsel] = 1'b1;
          tch[wsel] = 1'b1;
          ord       = ord_m;
        end
      end
      ACT_INVALIDATE: begin
        if (way_ok) begin
          if (vld[wsel]) begin
            ord = ord_l;
          end
          vld[wsel] = 1'b0;
          tch[wsel] = 1'b0;
        end
      end
      default: begin
      end
    endcase

    wo_d = wo_ext[WayInW-1:0];
    vt_d = vt_ext[TagInW-1:0];

    for (int k = 0; k < W; k++) begin
      new_row[k*TB +: TB]                = tg[k];
      new_row[TAGS_W + k]                = vld[k];
      new_row[TAGS_W + W + k]            = tch[k];
      new_row[TAGS_W + 2*W + k*WB +: WB] = ord[k];
    end
  end

  // Result valid: set on execute, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      hit_q <= hit_d;
      wo_q  <= wo_d;
      vv_q  <= vv_d;
      vt_q  <= vt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign way_out_o      = wo_q;
  assign victim_valid_o = vv_q;
  assign victim_tag_o   = vt_q;

endmodule

// ===== rtl/partitioned_lru_tag_store_unit.sv =====
// Top level of the way-partitioned set-associative LRU tag store.
// Each set holds two partitions of WAYS_PER_PART ways, each with its own LRU
// order; one RAM row per partition and set carries tags, valid and touched
// marks and the order. From acceptance to result a request is captured, the
// set index reduction multiply is registered, the RAM row is read into the
// read register, and the row is updated and the result register loaded.
// Each request reads, updates and writes back one whole row before the next is
// taken, so no new request is taken while one is in flight; results drain
// freely; a stalled result holds the controller and the input with it. After
// reset a clearing pass writes every row before the first request.
module partitioned_lru_tag_store_unit #(
  parameter int NUM_SETS      = 256,
  parameter int WAYS_PER_PART = 4,
  parameter int TAG_BITS      = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [plts_pkg::ActionW-1:0] action_i,
  input  logic                         partition_i,
  input  logic [plts_pkg::SetIdxW-1:0] set_index_i,
  input  logic [plts_pkg::TagInW-1:0]  tag_i,
  input  logic [plts_pkg::WayInW-1:0]  way_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [plts_pkg::WayInW-1:0]  way_out_o,
  output logic                         victim_valid_o,
  output logic [plts_pkg::TagInW-1:0]  victim_tag_o
);
  import plts_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  plts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  plts_dp #(
    .NUM_SETS     (NUM_SETS),
    .WAYS_PER_PART(WAYS_PER_PART),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .partition_i   (partition_i),
    .set_index_i   (set_index_i),
    .tag_i         (tag_i),
    .way_i         (way_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .way_out_o     (way_out_o),
    .victim_valid_o(victim_valid_o),
    .victim_tag_o  (victim_tag_o)
  );

endmodule

// ===== tb/partitioned_lru_tag_store_unit_tb.sv =====
// Self-checking testbench for the partitioned LRU tag store: random and directed requests.
module partitioned_lru_tag_store_unit_tb;
  import plts_pkg::*;

  localparam int NumSets   = 256;
  localparam int Ways      = 4;
  localparam int NumRandom = 950;
  localparam int WdogLimit = 5000;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               partition;
    logic [SetIdxW-1:0] set_index;
    logic [TagInW-1:0]  tag;
    logic [WayInW-1:0]  way;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [WayInW-1:0]  way_out;
    logic               victim_valid;
    logic [TagInW-1:0]  victim_tag;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ActionW-1:0] action_i = '0;
  logic partition_i = 1'b0;
  logic [SetIdxW-1:0] set_index_i = '0;
  logic [TagInW-1:0] tag_i = '0;
  logic [WayInW-1:0] way_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [WayInW-1:0] way_out_o;
  logic victim_valid_o;
  logic [TagInW-1:0] victim_tag_o;

  partitioned_lru_tag_store_unit #(
    .NUM_SETS(NumSets), .WAYS_PER_PART(Ways), .TAG_BITS(18)
  ) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .partition_i,
    .set_index_i, .tag_i, .way_i, .out_valid_o, .out_stall_i, .hit_o,
    .way_out_o, .victim_valid_o, .victim_tag_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the tag store
  logic [TagInW-1:0] tags_q  [2][NumSets][Ways];
  logic              valid_q [2][NumSets][Ways];
  logic              touch_q [2][NumSets][Ways];
  logic [WayInW-1:0] order_q [2][NumSets][Ways];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_hits = 0;
  bit   stim_done = 1'b0;
  bit   quiet = 1'b0;
  bit   hold_off = 1'b0;
  int   wdog = 0;
  logic [TagInW-1:0] tag_pool[8];

  function automatic int order_pos(int pt, int s, int w);
    for (int p = 0; p < Ways; p++) if (int'(order_q[pt][s][p]) == w) return p;
    return 0;
  endfunction

  function automatic void promote_way(int pt, int s, int w);
    int p;
    p = order_pos(pt, s, w);
    while (p > 0) begin
      order_q[pt][s][p] = order_q[pt][s][p-1];
      p--;
    end
    order_q[pt][s][0] = WayInW'(w);
  endfunction

  function automatic void demote_way(int pt, int s, int w);
    int p;
    p = order_pos(pt, s, w);
    while (p < Ways - 1) begin
      order_q[pt][s][p] = order_q[pt][s][p+1];
      p++;
    end
    order_q[pt][s][Ways-1] = WayInW'(w);
  endfunction

  // Apply one request to the shadow store and return its result
  function automatic rsp_t tag_store_step(req_t r);
    rsp_t o;
    int pt, s, w, k;
    o = '0;
    pt = int'(r.partition);
    s = int'(r.set_index) % NumSets;
    w = int'(r.way);
    case (r.action)
      ACT_ACCESS, ACT_PROBE: begin
        for (int p = 0; p < Ways; p++) begin
          k = int'(order_q[pt][s][p]);
          if (!o.hit && valid_q[pt][s][k] && tags_q[pt][s][k] == r.tag) begin
            o.hit = 1'b1;
            o.way_out = WayInW'(k);
          end
        end
        if (o.hit && r.action == ACT_ACCESS) begin
          promote_way(pt, s, int'(o.way_out));
          touch_q[pt][s][o.way_out] = 1'b1;
        end
      end
      ACT_VICTIM: begin
        k = int'(order_q[pt][s][Ways-1]);
        o.way_out = WayInW'(k);
        o.victim_valid = valid_q[pt][s][k];
        o.victim_tag = tags_q[pt][s][k];
      end
      ACT_INSERT: if (w < Ways) begin
        tags_q[pt][s][w] = r.tag;
        valid_q[pt][s][w] = 1'b1;
        touch_q[pt][s][w] = 1'b1;
        promote_way(pt, s, w);
      end
      ACT_INVALIDATE: if (w < Ways) begin
        if (valid_q[pt][s][w]) demote_way(pt, s, w);
        valid_q[pt][s][w] = 1'b0;
        touch_q[pt][s][w] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t make_req(logic [ActionW-1:0] a, bit pt, int s, int t, int w);
    req_t r;
    r.action = a;
    r.partition = pt;
    r.set_index = SetIdxW'(s);
    r.tag = TagInW'(t);
    r.way = WayInW'(w);
    return r;
  endfunction

  // Random request biased toward a few hot sets and recycled tags
  function automatic req_t rand_req();
    req_t r;
    int sel;
    r.action = ActionW'($urandom_range(0, 99) < 4 ? $urandom_range(5, 7)
                                                  : $urandom_range(0, 4));
    r.partition = 1'($urandom_range(0, 1));
    r.set_index = SetIdxW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    r.tag = sel < 7 ? tag_pool[3'($urandom_range(0, 7))] : TagInW'($urandom_range(0, 262143));
    r.way = WayInW'($urandom_range(0, 3));
    return r;
  endfunction

  initial begin
    for (int pt = 0; pt < 2; pt++)
      for (int s = 0; s < NumSets; s++)
        for (int k = 0; k < Ways; k++) begin
          tags_q[pt][s][k] = TagInW'(k);
          valid_q[pt][s][k] = 1'b0;
          touch_q[pt][s][k] = 1'b0;
          order_q[pt][s][k] = WayInW'(k);
        end
    for (int i = 0; i < 8; i++) tag_pool[i] = TagInW'($urandom_range(0, 262143));
    tag_pool[0] = '1;
    tag_pool[1] = '0;
    // Directed: reset contents, extremes, duplicates, odd actions
    pending_reqs.push_back(make_req(ACT_VICTIM, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_PROBE, 1, 255, 1, 0));
    pending_reqs.push_back(make_req(ACT_INSERT, 0, 0, 18'h3ffff, 3));
    pending_reqs.push_back(make_req(ACT_INSERT, 1, 255, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(ACT_ACCESS, 0, 0, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(ACT_PROBE, 1, 255, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(ACT_ACCESS, 1, 0, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(ACT_INSERT, 0, 0, 18'h3ffff, 1));
    pending_reqs.push_back(make_req(ACT_ACCESS, 0, 0, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(ACT_VICTIM, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_INVALIDATE, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(ACT_INVALIDATE, 0, 0, 0, 2));
    pending_reqs.push_back(make_req(ACT_VICTIM, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_PROBE, 0, 0, 18'h3ffff, 0));
    pending_reqs.push_back(make_req(3'd5, 0, 0, 18'h3ffff, 3));
    pending_reqs.push_back(make_req(3'd6, 1, 170, 18'h15555, 2));
    pending_reqs.push_back(make_req(3'd7, 1, 85, 18'h2aaaa, 1));
    pending_reqs.push_back(make_req(ACT_VICTIM, 1, 255, 0, 0));
    pending_reqs.push_back(make_req(ACT_INSERT, 1, 85, 18'h2aaaa, 2));
    pending_reqs.push_back(make_req(ACT_ACCESS, 1, 85, 18'h2aaaa, 0));
    for (int i = 0; i < NumRandom; i++) pending_reqs.push_back(rand_req());
    stim_done = 1'b1;
  end

  // Reset, then one long stretch without idling and one long receiver hold-off
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(posedge clk_i);
    quiet <= 1'b1;
    repeat (400) @(posedge clk_i);
    quiet <= 1'b0;
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Driver: present the next request, hold it while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          in_valid_i <= 1'b1;
          {action_i, partition_i, set_index_i, tag_i, way_i} <= pending_reqs[0];
          expected_rsps.push_back(tag_store_step(pending_reqs.pop_front()));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results and drive the receiver stall
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result");
          n_errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          n_checked++;
          if (exp_r.hit) n_hits++;
          if (hit_o !== exp_r.hit) begin
            $error("hit exp %0d got %0d", exp_r.hit, hit_o); n_errors++;
          end
          if (way_out_o !== exp_r.way_out) begin
            $error("way_out exp %0d got %0d", exp_r.way_out, way_out_o); n_errors++;
          end
          if (victim_valid_o !== exp_r.victim_valid) begin
            $error("victim_valid exp %0d got %0d", exp_r.victim_valid, victim_valid_o);
            n_errors++;
          end
          if (victim_tag_o !== exp_r.victim_tag) begin
            $error("victim_tag exp %0h got %0h", exp_r.victim_tag, victim_tag_o);
            n_errors++;
          end
        end
      end
      out_stall_i <= hold_off || (!quiet && $urandom_range(0, 99) < 16);
    end
  end

  // Watchdog and end of run; the expected queue is filled when a request is
  // driven, so an item still on the input counts as outstanding
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    wait (stim_done && rst_ni);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("checked %0d results (%0d hits) over all actions, both partitions", n_checked,
             n_hits);
    $display("included unknown actions, extreme tags and a long output hold-off");
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
